@@ hdl/i2cseq_pkg.sv @@
// shared types and constants of the i2c master transaction sequencer
package i2cseq_pkg;

  localparam int BUF_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;
  localparam int LEN_W = 6;
  localparam int DEPTH_CMP_W = 9;
  localparam logic [3:0] MAX_RETRIES_RST = 4'd3;
  localparam logic [7:0] ADDR_MASK = 8'hFE;

  typedef enum logic [1:0] {
    ACT_BEGIN_WRITE = 2'd0,
    ACT_BEGIN_READ  = 2'd1,
    ACT_BUS_DONE    = 2'd2,
    ACT_LOAD        = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    K_DROP,
    K_LOAD,
    K_BEGIN_W,
    K_BEGIN_R,
    K_DONE
  } kind_t;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_START  = 3'd1,
    CMD_RSTART = 3'd2,
    CMD_SEND   = 3'd3,
    CMD_RECV   = 3'd4,
    CMD_ACK    = 3'd5,
    CMD_NACK   = 3'd6,
    CMD_STOP   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_BUSY        = 2'd0,
    OUT_DONE        = 2'd1,
    OUT_NO_ADDR_ACK = 2'd2,
    OUT_NO_DATA_ACK = 2'd3
  } outcome_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_WAIT_START,
    PH_WAIT_ADDR,
    PH_WAIT_REG,
    PH_WAIT_SEND,
    PH_WAIT_RSTART,
    PH_WAIT_RADDR,
    PH_WAIT_RECV,
    PH_WAIT_RACK,
    PH_WAIT_STOP,
    PH_WAIT_ERRSTOP,
    PH_WAIT_RETRYSTOP
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  dev_addr;
    logic [7:0]  reg_cmd;
    logic [LEN_W-1:0] len;
    logic [4:0]  load_idx;
    logic [7:0]  load_byte;
    logic        ack;
    logic [7:0]  rx;
  } item_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  tx;
    logic        got;
    logic [4:0]  idx;
    logic [7:0]  value;
    outcome_t    outcome;
    logic        finished;
  } result_t;

endpackage

@@ hdl/i2cseq_ifs.sv @@
// channel interfaces: request input, bus command output, configuration write

interface i2cseq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [6:0] device_address;
  logic [7:0] register_command;
  logic [5:0] transfer_length;
  logic [4:0] load_index;
  logic [7:0] load_byte;
  logic       ack_seen;
  logic [7:0] rx_byte;

  modport source (
    output valid, action, device_address, register_command, transfer_length,
           load_index, load_byte, ack_seen, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, action, device_address, register_command, transfer_length,
           load_index, load_byte, ack_seen, rx_byte,
    output ready
  );
endinterface

interface i2cseq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_command;
  logic [7:0] tx_byte;
  logic       got_byte;
  logic [4:0] byte_index;
  logic [7:0] byte_value;
  logic [1:0] outcome;
  logic       finished;

  modport source (
    output valid, bus_command, tx_byte, got_byte, byte_index, byte_value,
           outcome, finished,
    input  ready
  );
  modport sink (
    input  valid, bus_command, tx_byte, got_byte, byte_index, byte_value,
           outcome, finished,
    output ready
  );
endinterface

interface i2cseq_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ hdl/i2c_master_transaction_sequencer.sv @@
// top level of the i2c master transaction sequencer
//
//   channel   direction  transfer moves
//   in_if     sink       begin write/read, bus done event or buffer load
//   out_if    source     next bus command, received byte and outcome
//   cfg_if    sink       max_retries write, always ready
//
// one item per cycle unless stalled: the front end pushes into a two-entry queue while it
// has room and the back end retires one queue entry per cycle through its state machine
// an input transfer is held in a queue slot, then its result in the output register
// loads always retire; other items wait while a result sits unaccepted at the output
// a result taken in a cycle frees the output register for the next one in that cycle
// the write buffer needs no clearing after reset; max_retries resets to 3
module i2c_master_transaction_sequencer #(
  parameter int BUF_DEPTH = i2cseq_pkg::BUF_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  i2cseq_in_if.sink     in_if,
  i2cseq_out_if.source  out_if,
  i2cseq_cfg_if.sink    cfg_if
);
  import i2cseq_pkg::*;

  logic       cfg_write;
  logic [3:0] retries_r, retries_nxt;

  logic    push_valid, push_ready;
  item_t   push_item;
  logic    head_valid, head_ready;
  item_t   head_item;
  logic    res_valid;
  result_t res;

  assign cfg_write    = cfg_if.valid;
  assign cfg_if.ready = 1'b1;
  assign retries_nxt  = (cfg_write && cfg_if.ready) ? cfg_if.data : retries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retries_r <= MAX_RETRIES_RST;
    end else begin
      retries_r <= retries_nxt;
    end
  end

  i2cseq_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  i2cseq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_item   (head_item)
  );

  i2cseq_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_retries (retries_r),
    .head_valid  (head_valid),
    .head_ready  (head_ready),
    .head_item   (head_item),
    .out_valid   (res_valid),
    .out_ready   (out_if.ready),
    .out_res     (res)
  );

  assign out_if.valid       = res_valid;
  assign out_if.bus_command = res.cmd;
  assign out_if.tx_byte     = res.tx;
  assign out_if.got_byte    = res.got;
  assign out_if.byte_index  = res.idx;
  assign out_if.byte_value  = res.value;
  assign out_if.outcome     = res.outcome;
  assign out_if.finished    = res.finished;

`ifndef NO_ASSERTIONS
  // the finishing result carries no bus command
  a_finish_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.finished |-> out_if.bus_command == CMD_NONE)
    else $error("finishing result carries a bus command");

  // an outcome is reported only when the transaction ends
  a_outcome_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.outcome != OUT_BUSY |-> out_if.finished)
    else $error("outcome reported before the transaction ends");

  // a received byte is always answered with ack or nack
  a_got_byte_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.got_byte |->
      (out_if.bus_command == CMD_ACK || out_if.bus_command == CMD_NACK))
    else $error("received byte without ack or nack");

  // a queue entry is retired only when it exists
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    head_ready |-> head_valid)
    else $error("back end retired an empty queue slot");
`endif

endmodule

@@ hdl/i2cseq_front.sv @@
// front end: takes requests and classifies them into queue items
module i2cseq_front #(
  parameter int BUF_DEPTH = i2cseq_pkg::BUF_DEPTH_DEF
) (
  i2cseq_in_if.sink          in_if,
  output logic               push_valid,
  input  logic               push_ready,
  output i2cseq_pkg::item_t  push_item
);
  import i2cseq_pkg::*;

  localparam logic [DEPTH_CMP_W-1:0] DEPTH_CMP = DEPTH_CMP_W'(BUF_DEPTH);

  logic [LEN_W-1:0] len;
  logic             idx_ok;

  assign push_valid  = in_if.valid;
  assign in_if.ready = push_ready;

  always_comb begin
    // zero length means one byte, longer than the buffer saturates
    len = in_if.transfer_length;
    if (len == '0) begin
      len = LEN_W'(1);
    end
    if ({3'b000, len} > DEPTH_CMP) begin
      len = LEN_W'(BUF_DEPTH);
    end
  end

  assign idx_ok = ({4'b0000, in_if.load_index} < DEPTH_CMP);

  always_comb begin
    push_item.dev_addr  = in_if.device_address;
    push_item.reg_cmd   = in_if.register_command;
    push_item.len       = len;
    push_item.load_idx  = in_if.load_index;
    push_item.load_byte = in_if.load_byte;
    push_item.ack       = in_if.ack_seen;
    push_item.rx        = in_if.rx_byte;
    case (in_if.action)
      ACT_BEGIN_WRITE: push_item.kind = K_BEGIN_W;
      ACT_BEGIN_READ:  push_item.kind = K_BEGIN_R;
      ACT_BUS_DONE:    push_item.kind = K_DONE;
      ACT_LOAD:        push_item.kind = idx_ok ? K_LOAD : K_DROP;
      default:         push_item.kind = K_DROP;
    endcase
  end

endmodule

@@ hdl/i2cseq_queue.sv @@
// two-entry queue between front and back end
module i2cseq_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  i2cseq_pkg::item_t  push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output i2cseq_pkg::item_t  pop_item
);
  import i2cseq_pkg::*;

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hdl/i2cseq_back.sv @@
// back end: transaction state machine, write buffer and result register
module i2cseq_back #(
  parameter int BUF_DEPTH = i2cseq_pkg::BUF_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [3:0]           max_retries,
  input  logic                 head_valid,
  output logic                 head_ready,
  input  i2cseq_pkg::item_t    head_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cseq_pkg::result_t  out_res
);
  import i2cseq_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [DEPTH_CMP_W-1:0] DEPTH_CMP = DEPTH_CMP_W'(BUF_DEPTH);

  phase_t           phase_r, phase_nxt;
  logic             is_read_r, is_read_nxt;
  logic [LEN_W-1:0] bcount_r, bcount_nxt;
  logic [3:0]       retry_r, retry_nxt;
  logic [6:0]       addr_r, addr_nxt;
  logic [7:0]       reg_r, reg_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  outcome_t         perr_r, perr_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r, res_nxt;

  logic [7:0] wbuf [BUF_DEPTH];
  logic [7:0] rd_data_r;
  logic       we;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [DEPTH_CMP_W-1:0] wr_ext, rd_ext;

  logic             out_free, fire, emit;
  logic [LEN_W-1:0] bcount_inc;
  logic [7:0]       send_val;

  assign out_free   = !out_valid_r || out_ready;
  assign fire       = head_valid && (out_free || head_item.kind == K_LOAD);
  assign head_ready = fire;
  assign bcount_inc = bcount_r + LEN_W'(1);
  assign send_val   = ({3'b000, bcount_r} < DEPTH_CMP) ? rd_data_r : 8'h00;

  assign wr_ext  = {4'b0000, head_item.load_idx};
  assign wr_addr = wr_ext[AW-1:0];
  assign rd_ext  = {3'b000, bcount_nxt};
  assign rd_addr = rd_ext[AW-1:0];

  // read data always tracks the entry at the next byte count, with write-through
  always_ff @(posedge clk) begin
    if (we) begin
      wbuf[wr_addr] <= head_item.load_byte;
    end
    if (we && wr_addr == rd_addr) begin
      rd_data_r <= head_item.load_byte;
    end else begin
      rd_data_r <= wbuf[rd_addr];
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    is_read_nxt = is_read_r;
    bcount_nxt  = bcount_r;
    retry_nxt   = retry_r;
    addr_nxt    = addr_r;
    reg_nxt     = reg_r;
    len_nxt     = len_r;
    perr_nxt    = perr_r;
    we          = 1'b0;
    emit        = 1'b0;
    res_nxt     = '{cmd: CMD_NONE, tx: 8'h00, got: 1'b0, idx: 5'd0, value: 8'h00,
                    outcome: OUT_BUSY, finished: 1'b0};
    if (fire) begin
      case (head_item.kind)
        K_LOAD: begin
          we = 1'b1;
        end
        K_BEGIN_W, K_BEGIN_R: begin
          if (phase_r == PH_IDLE) begin
            emit        = 1'b1;
            is_read_nxt = (head_item.kind == K_BEGIN_R);
            addr_nxt    = head_item.dev_addr;
            reg_nxt     = head_item.reg_cmd;
            len_nxt     = head_item.len;
            bcount_nxt  = '0;
            retry_nxt   = '0;
            perr_nxt    = OUT_BUSY;
            res_nxt.cmd = CMD_START;
            phase_nxt   = PH_WAIT_START;
          end
        end
        K_DONE: begin
          emit = (phase_r != PH_IDLE);
          case (phase_r)
            PH_WAIT_START: begin
              res_nxt.cmd = CMD_SEND;
              res_nxt.tx  = {addr_r, 1'b0} & ADDR_MASK;
              phase_nxt   = PH_WAIT_ADDR;
            end
            PH_WAIT_ADDR: begin
              if (head_item.ack) begin
                retry_nxt   = '0;
                res_nxt.cmd = CMD_SEND;
                res_nxt.tx  = reg_r;
                phase_nxt   = PH_WAIT_REG;
              end else if (retry_r < max_retries) begin
                retry_nxt   = retry_r + 4'd1;
                res_nxt.cmd = CMD_STOP;
                phase_nxt   = PH_WAIT_RETRYSTOP;
              end else begin
                perr_nxt    = OUT_NO_ADDR_ACK;
                res_nxt.cmd = CMD_STOP;
                phase_nxt   = PH_WAIT_ERRSTOP;
              end
            end
            PH_WAIT_REG, PH_WAIT_SEND: begin
              if (!head_item.ack) begin
                perr_nxt    = OUT_NO_DATA_ACK;
                res_nxt.cmd = CMD_STOP;
                phase_nxt   = PH_WAIT_ERRSTOP;
              end else if (phase_r == PH_WAIT_REG && is_read_r) begin
                res_nxt.cmd = CMD_RSTART;
                phase_nxt   = PH_WAIT_RSTART;
              end else if (phase_r == PH_WAIT_SEND && bcount_r >= len_r) begin
                res_nxt.cmd = CMD_STOP;
                phase_nxt   = PH_WAIT_STOP;
              end else begin
                res_nxt.cmd = CMD_SEND;
                res_nxt.tx  = send_val;
                bcount_nxt  = bcount_inc;
                phase_nxt   = PH_WAIT_SEND;
              end
            end
            PH_WAIT_RSTART: begin
              res_nxt.cmd = CMD_SEND;
              res_nxt.tx  = ({addr_r, 1'b0} & ADDR_MASK) | 8'h01;
              phase_nxt   = PH_WAIT_RADDR;
            end
            PH_WAIT_RADDR: begin
              if (head_item.ack) begin
                res_nxt.cmd = CMD_RECV;
                phase_nxt   = PH_WAIT_RECV;
              end else begin
                perr_nxt    = OUT_NO_DATA_ACK;
                res_nxt.cmd = CMD_STOP;
                phase_nxt   = PH_WAIT_ERRSTOP;
              end
            end
            PH_WAIT_RECV: begin
              res_nxt.got   = 1'b1;
              res_nxt.idx   = bcount_r[4:0];
              res_nxt.value = head_item.rx;
              bcount_nxt    = bcount_inc;
              res_nxt.cmd   = (bcount_inc >= len_r) ? CMD_NACK : CMD_ACK;
              phase_nxt     = PH_WAIT_RACK;
            end
            PH_WAIT_RACK: begin
              if (bcount_r >= len_r) begin
                res_nxt.cmd = CMD_STOP;
                phase_nxt   = PH_WAIT_STOP;
              end else begin
                res_nxt.cmd = CMD_RECV;
                phase_nxt   = PH_WAIT_RECV;
              end
            end
            PH_WAIT_STOP: begin
              bcount_nxt       = '0;
              res_nxt.outcome  = OUT_DONE;
              res_nxt.finished = 1'b1;
              phase_nxt        = PH_IDLE;
            end
            PH_WAIT_ERRSTOP: begin
              bcount_nxt       = '0;
              retry_nxt        = '0;
              res_nxt.outcome  = perr_r;
              res_nxt.finished = 1'b1;
              perr_nxt         = OUT_BUSY;
              phase_nxt        = PH_IDLE;
            end
            PH_WAIT_RETRYSTOP: begin
              bcount_nxt  = '0;
              res_nxt.cmd = CMD_START;
              phase_nxt   = PH_WAIT_START;
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      is_read_r   <= 1'b0;
      bcount_r    <= '0;
      retry_r     <= '0;
      addr_r      <= '0;
      reg_r       <= '0;
      len_r       <= '0;
      perr_r      <= OUT_BUSY;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      is_read_r   <= is_read_nxt;
      bcount_r    <= bcount_nxt;
      retry_r     <= retry_nxt;
      addr_r      <= addr_nxt;
      reg_r       <= reg_nxt;
      len_r       <= len_nxt;
      perr_r      <= perr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

@@ test/i2cseq_bus_checker.sv @@
`timescale 1ns / 1ps
// checker for the i2c sequencer: predicts every bus command and compares each result transfer
module i2cseq_bus_checker (
  input  logic  clk,
  input  logic  rst_n,
  i2cseq_in_if  in_ch,
  i2cseq_out_if out_ch,
  i2cseq_cfg_if cfg_ch,
  output int    fail_count,
  output int    cmds_waiting
);
  import i2cseq_pkg::*;

  // predicted sequencer state
  phase_t     seq_phase;
  logic       read_dir;
  logic [5:0] bytes_done;
  logic [3:0] retries_used;
  logic [3:0] retry_limit;
  logic [6:0] dev_addr_q;
  logic [7:0] reg_byte_q;
  logic [5:0] len_q;
  outcome_t   err_code;
  logic [7:0] tx_buffer [BUF_DEPTH_DEF];

  result_t expected_cmds[$];
  int      errs;

  task automatic start_abort(input outcome_t code);
    err_code  = code;
    seq_phase = PH_WAIT_ERRSTOP;
  endtask

  function automatic logic [7:0] next_data_byte();
    logic [7:0] b;
    b = tx_buffer[bytes_done[4:0]];
    bytes_done = bytes_done + 6'd1;
    seq_phase = PH_WAIT_SEND;
    return b;
  endfunction

  task automatic predict_bus_step(
    input  logic [1:0] act,
    input  logic [6:0] dev,
    input  logic [7:0] rcmd,
    input  logic [5:0] tlen,
    input  logic [4:0] lidx,
    input  logic [7:0] lbyte,
    input  logic       ack,
    input  logic [7:0] rx,
    output bit         emits,
    output result_t    res
  );
    emits = 1'b0;
    res = '0;
    case (act)
      ACT_LOAD: tx_buffer[lidx] = lbyte;
      ACT_BEGIN_WRITE, ACT_BEGIN_READ: begin
        if (seq_phase == PH_IDLE) begin
          read_dir     = (act == ACT_BEGIN_READ);
          dev_addr_q   = dev;
          reg_byte_q   = rcmd;
          len_q        = (tlen == 6'd0) ? 6'd1 :
                         (tlen > BUF_DEPTH_DEF) ? 6'(BUF_DEPTH_DEF) : tlen;
          bytes_done   = 6'd0;
          retries_used = 4'd0;
          err_code     = OUT_BUSY;
          res.cmd      = CMD_START;
          seq_phase    = PH_WAIT_START;
          emits        = 1'b1;
        end
      end
      default: begin
        // bus done event
        emits = (seq_phase != PH_IDLE);
        case (seq_phase)
          PH_WAIT_START: begin
            res.cmd   = CMD_SEND;
            res.tx    = {dev_addr_q, 1'b0};
            seq_phase = PH_WAIT_ADDR;
          end
          PH_WAIT_ADDR: begin
            if (ack) begin
              retries_used = 4'd0;
              res.cmd      = CMD_SEND;
              res.tx       = reg_byte_q;
              seq_phase    = PH_WAIT_REG;
            end else if (retries_used < retry_limit) begin
              retries_used = retries_used + 4'd1;
              res.cmd      = CMD_STOP;
              seq_phase    = PH_WAIT_RETRYSTOP;
            end else begin
              res.cmd = CMD_STOP;
              start_abort(OUT_NO_ADDR_ACK);
            end
          end
          PH_WAIT_REG: begin
            if (!ack) begin
              res.cmd = CMD_STOP;
              start_abort(OUT_NO_DATA_ACK);
            end else if (read_dir) begin
              res.cmd   = CMD_RSTART;
              seq_phase = PH_WAIT_RSTART;
            end else begin
              res.cmd = CMD_SEND;
              res.tx  = next_data_byte();
            end
          end
          PH_WAIT_SEND: begin
            if (!ack) begin
              res.cmd = CMD_STOP;
              start_abort(OUT_NO_DATA_ACK);
            end else if (bytes_done >= len_q) begin
              res.cmd   = CMD_STOP;
              seq_phase = PH_WAIT_STOP;
            end else begin
              res.cmd = CMD_SEND;
              res.tx  = next_data_byte();
            end
          end
          PH_WAIT_RSTART: begin
            res.cmd   = CMD_SEND;
            res.tx    = {dev_addr_q, 1'b1};
            seq_phase = PH_WAIT_RADDR;
          end
          PH_WAIT_RADDR: begin
            // a read address nack counts as a data failure
            if (ack) begin
              res.cmd   = CMD_RECV;
              seq_phase = PH_WAIT_RECV;
            end else begin
              res.cmd = CMD_STOP;
              start_abort(OUT_NO_DATA_ACK);
            end
          end
          PH_WAIT_RECV: begin
            res.got    = 1'b1;
            res.idx    = bytes_done[4:0];
            res.value  = rx;
            bytes_done = bytes_done + 6'd1;
            res.cmd    = (bytes_done >= len_q) ? CMD_NACK : CMD_ACK;
            seq_phase  = PH_WAIT_RACK;
          end
          PH_WAIT_RACK: begin
            if (bytes_done >= len_q) begin
              res.cmd   = CMD_STOP;
              seq_phase = PH_WAIT_STOP;
            end else begin
              res.cmd   = CMD_RECV;
              seq_phase = PH_WAIT_RECV;
            end
          end
          PH_WAIT_STOP: begin
            bytes_done   = 6'd0;
            seq_phase    = PH_IDLE;
            res.outcome  = OUT_DONE;
            res.finished = 1'b1;
          end
          PH_WAIT_ERRSTOP: begin
            bytes_done   = 6'd0;
            retries_used = 4'd0;
            seq_phase    = PH_IDLE;
            res.outcome  = err_code;
            res.finished = 1'b1;
            err_code     = OUT_BUSY;
          end
          PH_WAIT_RETRYSTOP: begin
            bytes_done = 6'd0;
            res.cmd    = CMD_START;
            seq_phase  = PH_WAIT_START;
          end
          default: emits = 1'b0;
        endcase
      end
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bit      emits;
    result_t want;
    if (!rst_n) begin
      seq_phase    = PH_IDLE;
      read_dir     = 1'b0;
      bytes_done   = 6'd0;
      retries_used = 4'd0;
      retry_limit  = MAX_RETRIES_RST;
      dev_addr_q   = 7'd0;
      reg_byte_q   = 8'd0;
      len_q        = 6'd0;
      err_code     = OUT_BUSY;
      expected_cmds.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_bus_step(in_ch.action, in_ch.device_address, in_ch.register_command,
                         in_ch.transfer_length, in_ch.load_index, in_ch.load_byte,
                         in_ch.ack_seen, in_ch.rx_byte, emits, want);
        if (emits) expected_cmds.push_back(want);
      end
      if (cfg_ch.valid && cfg_ch.ready) retry_limit = cfg_ch.data;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cmds.size() == 0) begin
          errs++;
          $display("%0t: result with none expected, expected nothing, actual bus_command %0d",
                   $time, out_ch.bus_command);
        end else begin
          want = expected_cmds.pop_front();
          check_field("bus_command", want.cmd, out_ch.bus_command);
          check_field("tx_byte", want.tx, out_ch.tx_byte);
          check_field("got_byte", want.got, out_ch.got_byte);
          check_field("byte_index", want.idx, out_ch.byte_index);
          check_field("byte_value", want.value, out_ch.byte_value);
          check_field("outcome", want.outcome, out_ch.outcome);
          check_field("finished", want.finished, out_ch.finished);
        end
      end
    end
    fail_count   <= errs;
    cmds_waiting <= expected_cmds.size();
  end

endmodule

@@ test/i2c_master_transaction_sequencer_test.sv @@
`timescale 1ns / 1ps
// top of the i2c sequencer test: clock, reset, transaction stimulus and the verdict
module i2c_master_transaction_sequencer_test;
  import i2cseq_pkg::*;

  localparam int NACK_ALL       = 1000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 210;
  localparam int EVENT_LIMIT    = 400;

  logic clk;
  logic rst_n;

  i2cseq_in_if  in_ch ();
  i2cseq_out_if out_ch ();
  i2cseq_cfg_if cfg_ch ();

  int        fail_count;
  int        cmds_waiting;
  int        finish_count;
  int        sent_items;
  int        quiet_cycles;
  bit        calm_spell;
  bit [31:0] loaded_mask;

  i2c_master_transaction_sequencer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  i2cseq_bus_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .cmds_waiting (cmds_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready <= calm_spell || ($urandom_range(99) >= 25);
  end

  // finished transactions, used to pace the bus done events
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready && out_ch.finished)
      finish_count <= finish_count + 1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_request(
    input action_t    act,
    input logic [6:0] dev,
    input logic [7:0] rc,
    input logic [5:0] tl,
    input logic [4:0] li,
    input logic [7:0] lb,
    input logic       ack,
    input logic [7:0] rx
  );
    @(negedge clk);
    while (!calm_spell && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.action           <= act;
    in_ch.device_address   <= dev;
    in_ch.register_command <= rc;
    in_ch.transfer_length  <= tl;
    in_ch.load_index       <= li;
    in_ch.load_byte        <= lb;
    in_ch.ack_seen         <= ack;
    in_ch.rx_byte          <= rx;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic load_entry(input logic [4:0] idx, input logic [7:0] value);
    send_request(ACT_LOAD, 7'($urandom), 8'($urandom), 6'($urandom), idx, value,
                 1'($urandom), 8'($urandom));
    loaded_mask[idx] = 1'b1;
  endtask

  task automatic done_event(input logic ack);
    send_request(ACT_BUS_DONE, 7'($urandom), 8'($urandom), 6'($urandom), 5'($urandom),
                 8'($urandom), ack, 8'($urandom));
  endtask

  task automatic begin_request(input bit rd, input logic [6:0] dev, input logic [7:0] rc,
                               input logic [5:0] tl);
    send_request(rd ? ACT_BEGIN_READ : ACT_BEGIN_WRITE, dev, rc, tl, 5'($urandom),
                 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  // one register transaction: begin, then bus done events until it finishes
  // nack_at picks a done event that is forced to report no ack, NACK_ALL makes all of them nack
  // stray_at puts an extra begin before done event stray_at + 1, while the block is surely busy
  task automatic run_transaction(input bit rd, input logic [6:0] dev, input logic [7:0] rc,
                                 input logic [5:0] tl, input int nack_at, input bit noisy,
                                 input int stray_at);
    int   span;
    int   seen;
    int   n;
    logic ack;
    span = (tl == 6'd0) ? 1 : (tl > BUF_DEPTH_DEF) ? BUF_DEPTH_DEF : int'(tl);
    // a write must never send a buffer entry that was not loaded
    if (!rd) begin
      for (int i = 0; i < span; i++)
        if (!loaded_mask[i]) load_entry(5'(i), 8'($urandom));
    end
    seen = finish_count;
    begin_request(rd, dev, rc, tl);
    n = 0;
    while (finish_count == seen && n < EVENT_LIMIT) begin
      if (n == stray_at)
        begin_request(1'($urandom), 7'($urandom), 8'($urandom), 6'($urandom));
      n++;
      if (nack_at == NACK_ALL || n == nack_at) ack = 1'b0;
      else if (noisy) ack = ($urandom_range(3) != 0);
      else ack = 1'b1;
      if ($urandom_range(15) == 0) load_entry(5'($urandom), 8'($urandom));
      done_event(ack);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (cmds_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_retry_limit(input logic [3:0] limit);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= limit;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [3:0] limit, input bit calm);
    int         stop_at;
    int         r;
    logic [5:0] tl;
    settle();
    write_retry_limit(limit);
    calm_spell = calm;
    // every setting also gets a transaction that runs out of address retries
    run_transaction(1'($urandom), 7'($urandom), 8'($urandom), 6'd1, NACK_ALL, 1'b0, -1);
    stop_at = sent_items + PHASE_ITEMS;
    while (sent_items < stop_at) begin
      r = $urandom_range(99);
      tl = (r < 80) ? 6'($urandom_range(6, 1)) :
           (r < 92) ? 6'($urandom_range(31, 7)) : 6'($urandom);
      run_transaction(1'($urandom), 7'($urandom), 8'($urandom), tl,
                      ($urandom_range(99) < 15) ? int'($urandom_range(6, 1)) : 0,
                      $urandom_range(99) < 40,
                      ($urandom_range(99) < 20) ? int'($urandom_range(2)) : -1);
      if ($urandom_range(7) == 0) done_event(1'($urandom));
      if ($urandom_range(3) == 0) load_entry(5'($urandom), 8'($urandom));
    end
    calm_spell = 1'b0;
  endtask

  initial begin
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.action           = ACT_BEGIN_WRITE;
    in_ch.device_address   = 7'd0;
    in_ch.register_command = 8'd0;
    in_ch.transfer_length  = 6'd0;
    in_ch.load_index       = 5'd0;
    in_ch.load_byte        = 8'd0;
    in_ch.ack_seen         = 1'b0;
    in_ch.rx_byte          = 8'd0;
    out_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.data            = 4'd0;
    calm_spell             = 1'b0;
    loaded_mask            = '0;
    finish_count           = 0;
    sent_items             = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed cases at the reset retry limit
    done_event(1'b1);
    load_entry(5'd0, 8'hFF);
    load_entry(5'd31, 8'h00);
    run_transaction(1'b0, 7'h7F, 8'hFF, 6'd63, 0, 1'b0, -1);
    run_transaction(1'b0, 7'h00, 8'h00, 6'd0, 0, 1'b0, -1);
    run_transaction(1'b1, 7'h7F, 8'hA5, 6'd1, 0, 1'b0, -1);
    run_transaction(1'b1, 7'h2A, 8'h5A, 6'd33, 0, 1'b0, -1);
    run_transaction(1'b0, 7'h55, 8'h0F, 6'd2, 2, 1'b0, -1);
    run_transaction(1'b0, 7'h33, 8'hF0, 6'd3, 3, 1'b0, -1);
    run_transaction(1'b0, 7'h4C, 8'h81, 6'd3, 4, 1'b0, -1);
    run_transaction(1'b1, 7'h11, 8'h7E, 6'd2, 5, 1'b0, -1);
    run_transaction(1'b1, 7'h6E, 8'h3C, 6'd2, NACK_ALL, 1'b0, -1);
    run_transaction(1'b0, 7'h01, 8'h10, 6'd1, 0, 1'b0, 0);
    run_transaction(1'b1, 7'h40, 8'h20, 6'd2, 0, 1'b0, 2);
    done_event(1'b0);

    random_phase(4'd0, 1'b0);
    random_phase(4'd15, 1'b0);
    random_phase(4'($urandom_range(14, 1)), 1'b1);
    random_phase(4'($urandom), 1'b0);
    random_phase(4'd1, 1'b0);

    settle();
    if (fail_count == 0 && cmds_waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/i2cseq_pkg.sv
hdl/i2cseq_ifs.sv
hdl/i2cseq_front.sv
hdl/i2cseq_queue.sv
hdl/i2cseq_back.sv
hdl/i2c_master_transaction_sequencer.sv
test/i2cseq_bus_checker.sv
test/i2c_master_transaction_sequencer_test.sv
